// ----- rtl/core/coverage_alpha_compositor_top_macros.svh -----
// Assertion macros used by the compositor blend module.
`ifndef COVERAGE_ALPHA_COMPOSITOR_TOP_MACROS_SVH
`define COVERAGE_ALPHA_COMPOSITOR_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define CAC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("compositor check failed");

// Check cons in the cycle after ante.
`define CAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("compositor check failed");

`endif

// ----- rtl/core/cac_pkg.sv -----
package cac_pkg;

  localparam int unsigned ALPHA_SHIFT = 24;
  localparam logic [31:0] RGB_MASK    = 32'h00ff_ffff;
  localparam logic [31:0] ALPHA_MASK  = 32'hff00_0000;
  localparam logic [7:0]  BYTE_MAX    = 8'hff;

  localparam logic [1:0] REG_FILL_COLOR = 2'd0;
  localparam logic [1:0] REG_LINE_COLOR = 2'd1;
  localparam logic [1:0] REG_SUBPIX_RES = 2'd2;

  localparam int unsigned RECIP_W      = 25;
  localparam int unsigned RECIP_SHIFT  = 24;
  localparam int unsigned NUM_W        = 24;
  localparam int unsigned BLEND_SHIFT  = 40;
  localparam logic [16:0] FULL_SQ      = 17'd65025;
  localparam logic [NUM_W-1:0] NUM_MAX = 24'd16581375;
  localparam longint unsigned BLEND_RECIP_L =
    ((64'd1 << BLEND_SHIFT) + 64'd65024) / 64'd65025;
  localparam logic [RECIP_W-1:0] BLEND_RECIP = RECIP_W'(BLEND_RECIP_L);

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_FILL,
    SEL_LINE,
    SEL_BLEND
  } cac_sel_t;

  typedef struct packed {
    logic [31:0]        fill_color;
    logic [31:0]        line_color;
    logic [RECIP_W-1:0] recip;
  } cac_cfg_t;

  typedef struct packed {
    logic [7:0] af;
    logic [7:0] al;
  } cac_alpha_t;

  // ceil(2^24 / (res*res)); resolution zero acts as one
  function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] res);
    logic [RECIP_W-1:0] m;
    unique case (res)
      4'd0:    m = 25'd16777216;
      4'd1:    m = 25'd16777216;
      4'd2:    m = 25'd4194304;
      4'd3:    m = 25'd1864136;
      4'd4:    m = 25'd1048576;
      4'd5:    m = 25'd671089;
      4'd6:    m = 25'd466034;
      4'd7:    m = 25'd342393;
      4'd8:    m = 25'd262144;
      4'd9:    m = 25'd207127;
      4'd10:   m = 25'd167773;
      4'd11:   m = 25'd138655;
      4'd12:   m = 25'd116509;
      4'd13:   m = 25'd99274;
      4'd14:   m = 25'd85599;
      4'd15:   m = 25'd74566;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/core/cac_cfg.sv -----
module cac_cfg import cac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cac_cfg_t    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fill_color <= '0;
      cfg.line_color <= '0;
      cfg.recip      <= recip_of(4'd4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILL_COLOR: cfg.fill_color <= cfg_data;
        REG_LINE_COLOR: cfg.line_color <= cfg_data;
        REG_SUBPIX_RES: cfg.recip      <= recip_of(cfg_data[3:0]);
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/cac_alpha.sv -----
module cac_alpha import cac_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cac_cfg_t   cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] fill_coverage,
  input  logic [7:0] line_coverage,
  output logic       out_valid,
  input  logic       out_ready,
  output cac_alpha_t alpha
);

  logic        v1;
  logic [15:0] pf;
  logic [15:0] pl;
  logic        ready1;
  logic        ready2;
  logic [40:0] qf;
  logic [40:0] ql;

  assign ready1   = !v1 || ready2;
  assign ready2   = !out_valid || out_ready;
  assign in_ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      pf <= {8'h00, cfg.fill_color[31:24]} * {8'h00, fill_coverage};
      pl <= {8'h00, cfg.line_color[31:24]} * {8'h00, line_coverage};
    end
  end

  // divide by full coverage through the reciprocal
  assign qf = {25'h0, pf} * {16'h0, cfg.recip};
  assign ql = {25'h0, pl} * {16'h0, cfg.recip};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      alpha.af <= (qf[40:24] > 17'(BYTE_MAX)) ? BYTE_MAX : qf[31:24];
      alpha.al <= (ql[40:24] > 17'(BYTE_MAX)) ? BYTE_MAX : ql[31:24];
    end
  end

endmodule

// ----- rtl/core/cac_blend.sv -----
`include "coverage_alpha_compositor_top_macros.svh"

module cac_blend import cac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cac_cfg_t    cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  cac_alpha_t  alpha,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel
);

  logic             v3;
  cac_sel_t         sel3;
  logic [7:0]       a3;
  logic [15:0]      wf;
  logic [15:0]      wl;
  logic             v4;
  cac_sel_t         sel4;
  logic [7:0]       a4;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] num_g;
  logic [NUM_W-1:0] num_b;
  logic             ready3;
  logic             ready4;
  logic             ready5;
  cac_sel_t         sel_next;
  logic [31:0]      pixel_next;

  function automatic logic [7:0] div_full_sq(input logic [NUM_W-1:0] num);
    logic [48:0] prod;
    prod = {25'h0, num} * {24'h0, BLEND_RECIP};
    return prod[47:40];
  endfunction

  function automatic logic [NUM_W-1:0] mix(input logic [15:0] w0, input logic [7:0] c0,
                                           input logic [15:0] w1, input logic [7:0] c1);
    return ({8'h00, w0} * {16'h0, c0}) + ({8'h00, w1} * {16'h0, c1});
  endfunction

  assign ready5   = !out_valid || out_ready;
  assign ready4   = !v4 || ready5;
  assign ready3   = !v3 || ready4;
  assign in_ready = ready3;

  always_comb begin
    priority if (alpha.af == 8'h00 && alpha.al == 8'h00) begin
      sel_next = SEL_ZERO;
    end else if (alpha.al == 8'h00) begin
      sel_next = SEL_FILL;
    end else if (alpha.af == 8'h00) begin
      sel_next = SEL_LINE;
    end else begin
      sel_next = SEL_BLEND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready3) begin
        v3 <= in_valid;
      end
      if (ready4) begin
        v4 <= v3;
      end
      if (ready5) begin
        out_valid <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && in_valid) begin
      sel3 <= sel_next;
      a3   <= (sel_next == SEL_FILL) ? alpha.af : alpha.al;
      wf   <= {8'h00, alpha.af} * {8'h00, BYTE_MAX - alpha.al};
      wl   <= {alpha.al, 8'h00} - {8'h00, alpha.al};
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && v3) begin
      sel4  <= sel3;
      a4    <= a3;
      num_r <= mix(wf, cfg.fill_color[23:16], wl, cfg.line_color[23:16]);
      num_g <= mix(wf, cfg.fill_color[15:8],  wl, cfg.line_color[15:8]);
      num_b <= mix(wf, cfg.fill_color[7:0],   wl, cfg.line_color[7:0]);
    end
  end

  always_comb begin
    unique case (sel4)
      SEL_ZERO:  pixel_next = '0;
      SEL_FILL:  pixel_next = ({24'h0, a4} << ALPHA_SHIFT) | (cfg.fill_color & RGB_MASK);
      SEL_LINE:  pixel_next = ({24'h0, a4} << ALPHA_SHIFT) | (cfg.line_color & RGB_MASK);
      SEL_BLEND: pixel_next = ALPHA_MASK |
                              {8'h00, div_full_sq(num_r), div_full_sq(num_g),
                               div_full_sq(num_b)};
      default:   pixel_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ready5 && v4) begin
      pixel <= pixel_next;
    end
  end

  `CAC_ASSERT_NOW(a_weight_sum, v3 && sel3 == SEL_BLEND, (17'(wf) + 17'(wl)) <= FULL_SQ)
  `CAC_ASSERT_NOW(a_num_bound, v4, num_r <= NUM_MAX && num_g <= NUM_MAX && num_b <= NUM_MAX)
  `CAC_ASSERT_NEXT(a_blend_opaque, v4 && ready5 && sel4 == SEL_BLEND, pixel[31:24] == BYTE_MAX)
  `CAC_ASSERT_NEXT(a_zero_pixel, v4 && ready5 && sel4 == SEL_ZERO, pixel == 32'h0)

endmodule

// ----- rtl/core/coverage_alpha_compositor_top.sv -----
// Channel   Handshake             Payload
// cfg       cfg_we                cfg_index[1:0], cfg_data[31:0]
// in        in_valid / in_ready   fill_coverage[7:0], line_coverage[7:0]
// out       out_valid / out_ready pixel[31:0]
//
// One item per cycle unless out_ready holds the output back; each item passes the stages below in order.
// Stages: coverage products, alpha division by reciprocal, blend weights,
// channel sums, division by 65025 into the output register.
// Each stage holds its own valid bit and fills bubbles while a later stage stalls.
// rst clears all valid bits and loads the register reset values.
module coverage_alpha_compositor_top import cac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  fill_coverage,
  input  logic [7:0]  line_coverage,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel
);

  cac_cfg_t   cfg;
  cac_alpha_t alpha;
  logic       alpha_valid;
  logic       alpha_ready;

  cac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cac_alpha u_alpha (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .fill_coverage (fill_coverage),
    .line_coverage (line_coverage),
    .out_valid     (alpha_valid),
    .out_ready     (alpha_ready),
    .alpha         (alpha)
  );

  cac_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (alpha_valid),
    .in_ready  (alpha_ready),
    .alpha     (alpha),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel     (pixel)
  );

endmodule
